FILE: rtl/quaternion_slerp_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion slerp block
// Each macro expands to a clocked property on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_SLERP_TOP_ASSERT_SVH
`define QUATERNION_SLERP_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define QS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("quaternion_slerp_top: check failed");

// Next-cycle implication
`define QS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("quaternion_slerp_top: check failed");

`else

`define QS_ASSERT_IMP(lbl, ante, cons)
`define QS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/qslerp_pkg.sv
// ----------------------------------------------------------------------------
// qslerp_pkg
// Shared constants, types and helper functions of the quaternion slerp block.
// ----------------------------------------------------------------------------
`default_nettype none

package qslerp_pkg;

  // Default fixed-point and iteration settings
  localparam int FRAC_BITS_DEF    = 14;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;

  // Angle datapath: Q30 radians in a signed word with headroom
  localparam int ANG_BITS = 30;
  localparam int CW       = 34;

  localparam logic signed [CW-1:0] HALF_PI_Q = 34'sd1686629713;
  localparam logic signed [CW-1:0] PI_Q      = 34'sd3373259426;
  localparam logic signed [CW-1:0] GAIN_INV  = 34'sd652032874;

  // Register map
  localparam logic [2:0] REG_LERP_THRESHOLD = 3'd0;
  localparam logic [14:0] LERP_THRESHOLD_RST = 15'd16383;

  // Per-item payload carried down the long pipeline
  typedef struct packed {
    logic [3:0][15:0] a;     // first quaternion
    logic [3:0][16:0] b;     // second quaternion, sign-corrected
    logic [14:0]      t;     // fraction
    logic [3:0][15:0] lin;   // linear blend result
    logic             lerp;  // take linear blend
    logic [30:0]      s30;   // sin(theta) in Q30
  } side_t;

  // arctan(2^-i) in Q30
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] v;
    unique case (i)
      0:  v = 32'd843314856;
      1:  v = 32'd497837829;
      2:  v = 32'd263043836;
      3:  v = 32'd133525158;
      4:  v = 32'd67021686;
      5:  v = 32'd33543515;
      6:  v = 32'd16775850;
      7:  v = 32'd8388437;
      8:  v = 32'd4194282;
      9:  v = 32'd2097149;
      10: v = 32'd1048575;
      11: v = 32'd524287;
      12: v = 32'd262143;
      13: v = 32'd131071;
      14: v = 32'd65535;
      15: v = 32'd32767;
      16: v = 32'd16383;
      17: v = 32'd8191;
      18: v = 32'd4095;
      19: v = 32'd2047;
      20: v = 32'd1023;
      21: v = 32'd511;
      22: v = 32'd255;
      23: v = 32'd127;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Clamp to the signed 16-bit range
  function automatic logic [15:0] sat16(input logic signed [63:0] v);
    logic [15:0] r;
    if (v > 64'sd32767) begin
      r = 16'h7fff;
    end else if (v < -64'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/quaternion_slerp_top.sv
// ----------------------------------------------------------------------------
// quaternion_slerp_top
// Fixed-point quaternion slerp: dot product, sign fix, linear or spherical
// blend with square-root, vectoring CORDIC, sine CORDIC and divider pipelines.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; the whole pipeline advances together and
//   holds while a finished item waits on out_tready.
// Reset: synchronous active-low rst_n clears all valid bits and sets
//   lerp_threshold to 16383; payload registers are not reset.
`default_nettype none

module quaternion_slerp_top #(
  parameter int FRAC_BITS    = qslerp_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = qslerp_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // APB-style configuration
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  // input items
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // first_w, first_x, first_y, first_z, second_w, second_x, second_y,
  // second_z (16 each), fraction (15), one zero pad bit
  input  wire logic [143:0] in_tdata,
  // result items
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // out_w, out_x, out_y, out_z (16 each)
  output logic [63:0]       out_tdata,
  // linear_path
  output logic              out_tuser
);

  import qslerp_pkg::*;

`include "quaternion_slerp_top_assert.svh"

  // Pipeline geometry
  localparam int CS     = CORDIC_STEPS;
  localparam int SQ_N   = 31;                       // root bits
  localparam int SQ_END = SQ_N;                     // root ready
  localparam int VE     = SQ_END + CS;              // theta ready
  localparam int SE     = VE + 3 + CS;              // sines ready
  localparam int QW     = (61 + FRAC_BITS) / 2 + 2; // quotient bits
  localparam int DE     = SE + 1 + QW;              // weights ready
  localparam int LAST   = DE + 3;                   // output stage
  localparam int NW     = CW + ANG_BITS;            // dividend bits
  localparam int DW     = FRAC_BITS + 1;
  localparam int OW     = ((FRAC_BITS > 15) ? FRAC_BITS : 15) + 2;
  localparam int PW     = CW + OW;
  localparam int PRW    = QW + 18;

  localparam logic [33:0] ONE34  = 34'(1) << FRAC_BITS;
  localparam logic [33:0] HALF34 = 34'(1) << (FRAC_BITS - 1);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [14:0] lerp_threshold_r;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lerp_threshold_r <= LERP_THRESHOLD_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == REG_LERP_THRESHOLD) begin
      lerp_threshold_r <= cfg_pwdata[14:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == REG_LERP_THRESHOLD) begin
      cfg_prdata = {17'd0, lerp_threshold_r};
    end
  end

  // --------------------------------------------------------------------------
  // Global advance: hold everything while the output item is not taken
  // --------------------------------------------------------------------------
  logic [LAST:0] vld_r;
  logic          pipe_en;

  assign pipe_en   = !vld_r[LAST] || out_tready;
  assign in_tready = pipe_en;

  // --------------------------------------------------------------------------
  // Stage 1: component products
  // --------------------------------------------------------------------------
  logic               s1_v_r;
  logic [15:0]        s1_a_r [4];
  logic [15:0]        s1_b_r [4];
  logic [14:0]        s1_t_r;
  logic signed [31:0] s1_p_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (pipe_en) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int k = 0; k < 4; k++) begin
        s1_a_r[k] <= in_tdata[16*k +: 16];
        s1_b_r[k] <= in_tdata[64+16*k +: 16];
        s1_p_r[k] <= $signed(in_tdata[16*k +: 16]) * $signed(in_tdata[64+16*k +: 16]);
      end
      s1_t_r <= in_tdata[142:128];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: dot sum, sign fix, rounding, path choice, differences
  // --------------------------------------------------------------------------
  logic signed [33:0] s2_sum;
  logic [33:0]        s2_mag;
  logic [33:0]        s2_rdot;
  logic               s2_neg;
  logic signed [16:0] s2_bn [4];

  always_comb begin
    s2_sum = 34'(s1_p_r[0]) + 34'(s1_p_r[1]) + 34'(s1_p_r[2]) + 34'(s1_p_r[3]);
    s2_neg = s2_sum[33];
    s2_mag = s2_neg ? 34'(-s2_sum) : 34'(s2_sum);
    s2_rdot = (s2_mag + HALF34) >> FRAC_BITS;
    for (int k = 0; k < 4; k++) begin
      s2_bn[k] = s2_neg ? -17'($signed(s1_b_r[k])) : 17'($signed(s1_b_r[k]));
    end
  end

  logic               s2_v_r;
  logic [15:0]        s2_a_r [4];
  logic [16:0]        s2_b_r [4];
  logic signed [17:0] s2_d_r [4];
  logic [14:0]        s2_t_r;
  logic [DW-1:0]      s2_dot_r;
  logic               s2_lerp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (pipe_en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int k = 0; k < 4; k++) begin
        s2_a_r[k] <= s1_a_r[k];
        s2_b_r[k] <= s2_bn[k];
        s2_d_r[k] <= 18'(s2_bn[k]) - 18'($signed(s1_a_r[k]));
      end
      s2_t_r    <= s1_t_r;
      s2_dot_r  <= (s2_rdot > ONE34) ? DW'(ONE34) : DW'(s2_rdot);
      s2_lerp_r <= (s2_rdot > 34'(lerp_threshold_r)) || (s2_rdot >= ONE34);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: lerp products and dot square
  // --------------------------------------------------------------------------
  logic               s3_v_r;
  logic [15:0]        s3_a_r [4];
  logic [16:0]        s3_b_r [4];
  logic signed [33:0] s3_lp_r [4];
  logic [14:0]        s3_t_r;
  logic [2*DW-1:0]    s3_dsq_r;
  logic [DW-1:0]      s3_dot_r;
  logic               s3_lerp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (pipe_en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int k = 0; k < 4; k++) begin
        s3_a_r[k]  <= s2_a_r[k];
        s3_b_r[k]  <= s2_b_r[k];
        s3_lp_r[k] <= 34'($signed({1'b0, s2_t_r})) * 34'(s2_d_r[k]);
      end
      s3_t_r    <= s2_t_r;
      s3_dsq_r  <= (2*DW)'(s2_dot_r) * (2*DW)'(s2_dot_r);
      s3_dot_r  <= s2_dot_r;
      s3_lerp_r <= s2_lerp_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4 (long pipe index 0): lerp result, radicand, side payload
  // --------------------------------------------------------------------------
  side_t              s4_side;
  logic signed [34:0] s4_lsh [4];
  logic signed [35:0] s4_lsum [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      s4_lsh[k]  = (35'(s3_lp_r[k]) + 35'($signed(HALF34))) >>> FRAC_BITS;
      s4_lsum[k] = 36'($signed(s3_a_r[k])) + 36'(s4_lsh[k]);
      s4_side.a[k]   = s3_a_r[k];
      s4_side.b[k]   = s3_b_r[k];
      s4_side.lin[k] = sat16(64'(s4_lsum[k]));
    end
    s4_side.t    = s3_t_r;
    s4_side.lerp = s3_lerp_r;
    s4_side.s30  = '0;
  end

  side_t side_r [LAST];

  // square root pipeline registers
  logic [61:0] sq_rad_r [SQ_N+1];
  logic [30:0] sq_d30_r [SQ_N+1];
  logic [30:0] sq_q_r   [SQ_N+1];
  logic [32:0] sq_rm_r  [SQ_N+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[LAST-1:0], s3_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      side_r[0] <= s4_side;
    end
  end

  // advance the payload; pick up the root once it is ready
  for (genvar j = 1; j < LAST; j++) begin : g_side
    side_t side_nxt;

    always_comb begin
      side_nxt = side_r[j-1];
      if (j == SQ_END + 1) begin
        side_nxt.s30 = sq_q_r[SQ_END];
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        side_r[j] <= side_nxt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Square root of 2^60 - d30^2, two radicand bits per stage
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sq_rad_r[0] <= (62'(1) << 60) - (62'(s3_dsq_r) << (60 - 2*FRAC_BITS));
      sq_d30_r[0] <= 31'(s3_dot_r) << (ANG_BITS - FRAC_BITS);
      sq_q_r[0]   <= '0;
      sq_rm_r[0]  <= '0;
    end
  end

  for (genvar i = 1; i <= SQ_N; i++) begin : g_sqrt
    logic [34:0] rsh;
    logic [34:0] trial;
    logic        take;

    always_comb begin
      rsh   = {sq_rm_r[i-1], sq_rad_r[i-1][2*(SQ_N-i)+1 -: 2]};
      trial = {2'b00, sq_q_r[i-1], 2'b01};
      take  = (rsh >= trial);
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        sq_rad_r[i] <= sq_rad_r[i-1];
        sq_d30_r[i] <= sq_d30_r[i-1];
        sq_q_r[i]   <= {sq_q_r[i-1][29:0], take};
        sq_rm_r[i]  <= take ? 33'(rsh - trial) : 33'(rsh);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Vectoring CORDIC: theta = atan2(s30, d30)
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] vx_r [CS+1];
  logic signed [CW-1:0] vy_r [CS+1];
  logic signed [CW-1:0] vz_r [CS+1];

  always_comb begin
    vx_r[0] = CW'(sq_d30_r[SQ_N]);
    vy_r[0] = CW'(sq_q_r[SQ_N]);
    vz_r[0] = '0;
  end

  for (genvar i = 1; i <= CS; i++) begin : g_vec
    logic signed [CW-1:0] ang;

    assign ang = CW'(atan_q30(i-1));

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        if (vy_r[i-1] > 0) begin
          vx_r[i] <= vx_r[i-1] + (vy_r[i-1] >>> (i-1));
          vy_r[i] <= vy_r[i-1] - (vx_r[i-1] >>> (i-1));
          vz_r[i] <= vz_r[i-1] + ang;
        end else begin
          vx_r[i] <= vx_r[i-1] - (vy_r[i-1] >>> (i-1));
          vy_r[i] <= vy_r[i-1] + (vx_r[i-1] >>> (i-1));
          vz_r[i] <= vz_r[i-1] - ang;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Angles (1-t)theta and t*theta: multiply, round, fold into +-pi/2
  // --------------------------------------------------------------------------
  logic signed [OW-1:0] omt;
  logic signed [PW-1:0] pm_r [2];
  logic signed [PW-1:0] pr_sh [2];
  logic signed [CW-1:0] ph_r [2];
  logic signed [CW-1:0] fd_r [2];

  assign omt = $signed(OW'(ONE34) - OW'(side_r[VE].t));

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      pm_r[0] <= PW'(vz_r[CS]) * PW'(omt);
      pm_r[1] <= PW'(vz_r[CS]) * PW'($signed({1'b0, side_r[VE].t}));
    end
  end

  for (genvar p = 0; p < 2; p++) begin : g_ang
    assign pr_sh[p] = (pm_r[p] + PW'($signed(HALF34))) >>> FRAC_BITS;

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        ph_r[p] <= CW'(pr_sh[p]);
        if (ph_r[p] > HALF_PI_Q) begin
          fd_r[p] <= PI_Q - ph_r[p];
        end else if (ph_r[p] < -HALF_PI_Q) begin
          fd_r[p] <= -PI_Q - ph_r[p];
        end else begin
          fd_r[p] <= ph_r[p];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Rotation CORDIC: sines of both angles
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] sx_r [2][CS+1];
  logic signed [CW-1:0] sy_r [2][CS+1];
  logic signed [CW-1:0] sz_r [2][CS+1];

  for (genvar p = 0; p < 2; p++) begin : g_sin
    always_comb begin
      sx_r[p][0] = GAIN_INV;
      sy_r[p][0] = '0;
      sz_r[p][0] = fd_r[p];
    end

    for (genvar i = 1; i <= CS; i++) begin : g_step
      logic signed [CW-1:0] ang;

      assign ang = CW'(atan_q30(i-1));

      always_ff @(posedge clk) begin
        if (pipe_en) begin
          if (sz_r[p][i-1] >= 0) begin
            sx_r[p][i] <= sx_r[p][i-1] - (sy_r[p][i-1] >>> (i-1));
            sy_r[p][i] <= sy_r[p][i-1] + (sx_r[p][i-1] >>> (i-1));
            sz_r[p][i] <= sz_r[p][i-1] - ang;
          end else begin
            sx_r[p][i] <= sx_r[p][i-1] + (sy_r[p][i-1] >>> (i-1));
            sy_r[p][i] <= sy_r[p][i-1] - (sx_r[p][i-1] >>> (i-1));
            sz_r[p][i] <= sz_r[p][i-1] + ang;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Weights: sin * 2^30 / s30, truncated toward zero, one quotient bit a stage
  // --------------------------------------------------------------------------
  logic [30:0]   dv_rem_r [2][QW+1];
  logic [QW-1:0] dv_nb_r  [2][QW+1];
  logic [QW-1:0] dv_q_r   [2][QW+1];
  logic          dv_neg_r [2][QW+1];
  logic signed [QW:0] w_r [2];

  for (genvar p = 0; p < 2; p++) begin : g_div
    logic [CW-1:0] mag;
    logic [NW-1:0] num;

    always_comb begin
      mag = sy_r[p][CS][CW-1] ? CW'(-sy_r[p][CS]) : CW'(sy_r[p][CS]);
      num = {mag, {ANG_BITS{1'b0}}};
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        dv_rem_r[p][0] <= 31'(num[NW-1:QW]);
        dv_nb_r[p][0]  <= num[QW-1:0];
        dv_q_r[p][0]   <= '0;
        dv_neg_r[p][0] <= sy_r[p][CS][CW-1];
      end
    end

    for (genvar i = 1; i <= QW; i++) begin : g_step
      logic [31:0] rsh;
      logic [31:0] dvs;
      logic        take;

      always_comb begin
        rsh  = {dv_rem_r[p][i-1], dv_nb_r[p][i-1][QW-1]};
        dvs  = {1'b0, side_r[SE+i].s30};
        take = (rsh >= dvs);
      end

      always_ff @(posedge clk) begin
        if (pipe_en) begin
          dv_rem_r[p][i] <= take ? 31'(rsh - dvs) : 31'(rsh);
          dv_nb_r[p][i]  <= dv_nb_r[p][i-1] << 1;
          dv_q_r[p][i]   <= {dv_q_r[p][i-1][QW-2:0], take};
          dv_neg_r[p][i] <= dv_neg_r[p][i-1];
        end
      end
    end

    // apply the sign of the sine
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        w_r[p] <= dv_neg_r[p][QW] ? -$signed({1'b0, dv_q_r[p][QW]})
                                  : $signed({1'b0, dv_q_r[p][QW]});
      end
    end
  end

  // --------------------------------------------------------------------------
  // Weighted sum and output register
  // --------------------------------------------------------------------------
  logic signed [PRW-1:0] wa_r [4];
  logic signed [PRW-1:0] wb_r [4];
  logic signed [PRW:0]   fsum [4];
  logic signed [PRW:0]   fsh  [4];
  logic [15:0]           out_q_r [4];
  logic                  out_lin_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int k = 0; k < 4; k++) begin
        wa_r[k] <= PRW'(w_r[0]) * PRW'($signed(side_r[DE+1].a[k]));
        wb_r[k] <= PRW'(w_r[1]) * PRW'($signed(side_r[DE+1].b[k]));
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      fsum[k] = (PRW+1)'(wa_r[k]) + (PRW+1)'(wb_r[k]);
      fsh[k]  = (fsum[k] + ((PRW+1)'(1) <<< (ANG_BITS - 1))) >>> ANG_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int k = 0; k < 4; k++) begin
        out_q_r[k] <= side_r[LAST-1].lerp ? side_r[LAST-1].lin[k] : sat16(64'(fsh[k]));
      end
      out_lin_r <= side_r[LAST-1].lerp;
    end
  end

  assign out_tvalid = vld_r[LAST];
  assign out_tdata  = {out_q_r[3], out_q_r[2], out_q_r[1], out_q_r[0]};
  assign out_tuser  = out_lin_r;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `QS_ASSERT_NXT(a_stall_hold, !pipe_en, $stable(vld_r))
  `QS_ASSERT_IMP(a_root_nonzero, vld_r[SQ_END+1] && !side_r[SQ_END+1].lerp, side_r[SQ_END+1].s30 != '0)
  `QS_ASSERT_IMP(a_div_range, vld_r[SE+1] && !side_r[SE+1].lerp, (dv_rem_r[0][0] < side_r[SE+1].s30) && (dv_rem_r[1][0] < side_r[SE+1].s30))

endmodule

`default_nettype wire
